/* src/char_class_range_parser_defines.svh */
`ifndef CHAR_CLASS_RANGE_PARSER_DEFINES_SVH
`define CHAR_CLASS_RANGE_PARSER_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define CCRP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ccrp check failed");

// Next-cycle implication, checked at every clock edge outside reset.
`define CCRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ccrp check failed");

`endif

/* src/ccrp_pkg.sv */
`timescale 1ns / 1ps

package ccrp_pkg;

  localparam int CodeW    = 21;
  localparam int HexValW  = 16;
  localparam int HexLeftW = 3;

  // Op queue between the parser and the result stage
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [CodeW-1:0] CODE_ALL_ONES = {CodeW{1'b1}};
  localparam logic [CodeW-1:0] CODE_NONE     = '0;

  // Characters with a meaning inside a class body
  localparam logic [CodeW-1:0] CH_CARET   = 21'h5E;
  localparam logic [CodeW-1:0] CH_DASH    = 21'h2D;
  localparam logic [CodeW-1:0] CH_BSLASH  = 21'h5C;
  localparam logic [CodeW-1:0] CH_LOWER_U = 21'h75;
  localparam logic [CodeW-1:0] CH_LOWER_X = 21'h78;
  localparam logic [CodeW-1:0] CH_LOWER_N = 21'h6E;
  localparam logic [CodeW-1:0] CH_LOWER_T = 21'h74;
  localparam logic [CodeW-1:0] CH_LOWER_R = 21'h72;
  localparam logic [CodeW-1:0] CH_LOWER_F = 21'h66;
  localparam logic [CodeW-1:0] CH_LOWER_V = 21'h76;

  // Control codes for the letter escapes
  localparam logic [CodeW-1:0] CODE_LF = 21'd10;
  localparam logic [CodeW-1:0] CODE_HT = 21'd9;
  localparam logic [CodeW-1:0] CODE_CR = 21'd13;
  localparam logic [CodeW-1:0] CODE_FF = 21'd12;
  localparam logic [CodeW-1:0] CODE_VT = 21'd11;

  localparam logic [HexLeftW-1:0] HEX_LEFT_U = 3'd4;
  localparam logic [HexLeftW-1:0] HEX_LEFT_X = 3'd2;

  // Action codes of an input word
  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_END  = 1'b1;

  typedef enum logic [2:0] {
    ESC_NONE   = 3'b001,
    ESC_LETTER = 3'b010,
    ESC_HEX    = 3'b100
  } esc_state_t;

  // One queued op: a range, a terminator, or a flush followed by a terminator
  typedef struct packed {
    logic             has_range;
    logic             has_term;
    logic             negated;
    logic [CodeW-1:0] lo;
    logic [CodeW-1:0] hi;
  } op_t;

  // Returns {bad, digit}; bad is set for anything that is not a hex digit
  function automatic logic [4:0] hex_digit(input logic [CodeW-1:0] c);
    logic [CodeW-1:0] t;
    logic [4:0]       r;
    r = 5'b10000;
    if (c >= 21'h30 && c <= 21'h39) begin
      t = c - 21'h30;
      r = {1'b0, t[3:0]};
    end else if (c >= 21'h61 && c <= 21'h66) begin
      t = c - 21'h57;
      r = {1'b0, t[3:0]};
    end else if (c >= 21'h41 && c <= 21'h46) begin
      t = c - 21'h37;
      r = {1'b0, t[3:0]};
    end
    return r;
  endfunction

endpackage

/* src/ccrp_front.sv */
`timescale 1ns / 1ps
`include "char_class_range_parser_defines.svh"

module ccrp_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      action,
  input  logic [ccrp_pkg::CodeW-1:0] char_code,
  output logic                      op_valid,
  output ccrp_pkg::op_t             op
);
  import ccrp_pkg::*;

  logic                at_start, at_start_next;
  logic                negate_flag, negate_flag_next;
  logic [CodeW-1:0]    pending_char, pending_char_next;
  logic                joiner_seen, joiner_seen_next;
  esc_state_t          escape_mode, escape_mode_next;
  logic [HexLeftW-1:0] hex_left, hex_left_next;
  logic [HexValW-1:0]  hex_value, hex_value_next;
  logic                hex_bad, hex_bad_next;

  logic             take;
  logic [CodeW-1:0] take_val;
  logic             emit;
  logic [4:0]       dig;

  assign dig = hex_digit(char_code);

  // Classify the word, then run finished characters through pending/joiner
  always_comb begin
    at_start_next     = at_start;
    negate_flag_next  = negate_flag;
    pending_char_next = pending_char;
    joiner_seen_next  = joiner_seen;
    escape_mode_next  = escape_mode;
    hex_left_next     = hex_left;
    hex_value_next    = hex_value;
    hex_bad_next      = hex_bad;
    take              = 1'b0;
    take_val          = char_code;
    emit              = 1'b0;
    op.has_range      = 1'b0;
    op.has_term       = 1'b0;
    op.negated        = negate_flag;
    op.lo             = pending_char;
    op.hi             = pending_char;

    if (action == ACT_END) begin
      // flush, terminate, back to reset state
      emit              = 1'b1;
      op.has_range      = (pending_char != CODE_NONE);
      op.has_term       = 1'b1;
      at_start_next     = 1'b1;
      negate_flag_next  = 1'b0;
      pending_char_next = CODE_NONE;
      joiner_seen_next  = 1'b0;
      escape_mode_next  = ESC_NONE;
      hex_left_next     = '0;
      hex_value_next    = '0;
      hex_bad_next      = 1'b0;
    end else begin
      unique case (escape_mode)
        ESC_LETTER: begin
          escape_mode_next = ESC_NONE;
          if (char_code == CH_LOWER_U || char_code == CH_LOWER_X) begin
            escape_mode_next = ESC_HEX;
            hex_left_next    = (char_code == CH_LOWER_U) ? HEX_LEFT_U : HEX_LEFT_X;
            hex_value_next   = '0;
            hex_bad_next     = 1'b0;
          end else begin
            take = 1'b1;
            unique case (char_code)
              CH_LOWER_N: take_val = CODE_LF;
              CH_LOWER_T: take_val = CODE_HT;
              CH_LOWER_R: take_val = CODE_CR;
              CH_LOWER_F: take_val = CODE_FF;
              CH_LOWER_V: take_val = CODE_VT;
              default:    take_val = char_code;
            endcase
          end
        end
        ESC_HEX: begin
          hex_bad_next  = hex_bad | dig[4];
          if (!dig[4]) hex_value_next = {hex_value[HexValW-5:0], dig[3:0]};
          hex_left_next = hex_left - 1'b1;
          if (hex_left_next == '0) begin
            escape_mode_next = ESC_NONE;
            take             = 1'b1;
            take_val         = hex_bad_next ? CODE_ALL_ONES
                                            : {{(CodeW-HexValW){1'b0}}, hex_value_next};
          end
        end
        default: begin
          at_start_next = 1'b0;
          if (at_start && char_code == CH_CARET) begin
            negate_flag_next = 1'b1;
          end else if (char_code == CH_DASH) begin
            joiner_seen_next = 1'b1;
          end else if (char_code == CH_BSLASH) begin
            escape_mode_next = ESC_LETTER;
          end else begin
            take = 1'b1;
          end
        end
      endcase

      // pending/joiner logic
      if (take) begin
        if (joiner_seen) begin
          emit              = 1'b1;
          op.has_range      = 1'b1;
          op.hi             = take_val;
          pending_char_next = CODE_NONE;
          joiner_seen_next  = 1'b0;
        end else begin
          if (pending_char != CODE_NONE) begin
            emit         = 1'b1;
            op.has_range = 1'b1;
          end
          pending_char_next = take_val;
        end
      end
    end
  end

  assign op_valid = in_valid && emit;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      at_start     <= 1'b1;
      negate_flag  <= 1'b0;
      pending_char <= CODE_NONE;
      joiner_seen  <= 1'b0;
      escape_mode  <= ESC_NONE;
      hex_left     <= '0;
      hex_value    <= '0;
      hex_bad      <= 1'b0;
    end else if (in_valid) begin
      at_start     <= at_start_next;
      negate_flag  <= negate_flag_next;
      pending_char <= pending_char_next;
      joiner_seen  <= joiner_seen_next;
      escape_mode  <= escape_mode_next;
      hex_left     <= hex_left_next;
      hex_value    <= hex_value_next;
      hex_bad      <= hex_bad_next;
    end
  end

  // An end word always leaves the parser at the start of a new class
  `CCRP_ASSERT_NEXT(a_end_restarts, clk, rst, in_valid && action == ACT_END,
                    at_start && escape_mode == ESC_NONE && pending_char == CODE_NONE)
  // Hex digit counter runs only while collecting hex
  `CCRP_ASSERT_NOW(a_hex_left_mode, clk, rst, hex_left != '0, escape_mode == ESC_HEX)

endmodule

/* src/ccrp_queue.sv */
`timescale 1ns / 1ps
`include "char_class_range_parser_defines.svh"

module ccrp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ccrp_pkg::op_t wdata,
  input  logic          pop,
  output ccrp_pkg::op_t rdata,
  output logic          full,
  output logic          empty
);
  import ccrp_pkg::*;

  op_t                  mem [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueueCntW-1:0] count;

  assign full  = (count == QueueCntW'(QueueDepth));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `CCRP_ASSERT_NOW(a_no_overflow, clk, rst, push, !full)
  `CCRP_ASSERT_NOW(a_no_underflow, clk, rst, pop, !empty)

endmodule

/* src/ccrp_back.sv */
`timescale 1ns / 1ps
`include "char_class_range_parser_defines.svh"

module ccrp_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       op_valid,
  input  ccrp_pkg::op_t              op,
  output logic                       op_take,
  input  logic                       pop,
  output logic                       empty,
  output logic [ccrp_pkg::CodeW-1:0] range_low,
  output logic [ccrp_pkg::CodeW-1:0] range_high,
  output logic                       negated,
  output logic                       is_terminator,
  output logic                       last_of_run
);
  import ccrp_pkg::*;

  logic out_valid;
  logic phase;       // range part of the head op already sent
  logic pop_ok;
  logic load;
  logic part_range;

  assign pop_ok     = pop && out_valid;
  assign load       = op_valid && (!out_valid || pop_ok);
  assign part_range = op.has_range && !phase;
  assign op_take    = load && !(part_range && op.has_term);
  assign empty      = !out_valid;

  // Output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= part_range && op.has_term;
      end else if (pop_ok) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output word
  always_ff @(posedge clk) begin
    if (load) begin
      negated <= op.negated;
      if (part_range) begin
        range_low     <= op.lo;
        range_high    <= op.hi;
        is_terminator <= 1'b0;
        last_of_run   <= !op.has_term;
      end else begin
        range_low     <= CODE_NONE;
        range_high    <= CODE_NONE;
        is_terminator <= 1'b1;
        last_of_run   <= 1'b1;
      end
    end
  end

  // Half-sent op must still be at the head of the queue
  `CCRP_ASSERT_NOW(a_phase_holds_op, clk, rst, phase, op_valid && op.has_term)
  // Every queued op carries something to send
  `CCRP_ASSERT_NOW(a_op_nonempty, clk, rst, op_valid, op.has_range || op.has_term)

endmodule

/* src/char_class_range_parser.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Word
// -------   ---------  -----------------  ---------------------------------------------
// input     in         push / full        action, char_code
// result    out        empty / pop        range_low, range_high, negated,
//                                         is_terminator, last_of_run
//
// Flow: one input word per cycle while full is low. A result word passes through the op
// queue and then the output register before it reaches the ports.
// An end word with a pending character yields two result words; the single output
// register sends them one after the other on the result side.
// A 4-entry op queue sits between the parser and the output register, so full
// rises only when four ops wait; then the parser stalls.
// Reset (rst, synchronous) empties the queue and returns the parser to class start.

module char_class_range_parser (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic                       action,
  input  logic [ccrp_pkg::CodeW-1:0] char_code,
  output logic                       empty,
  input  logic                       pop,
  output logic [ccrp_pkg::CodeW-1:0] range_low,
  output logic [ccrp_pkg::CodeW-1:0] range_high,
  output logic                       negated,
  output logic                       is_terminator,
  output logic                       last_of_run
);
  import ccrp_pkg::*;

  logic in_valid;
  logic q_push;
  op_t  q_wdata;
  op_t  q_rdata;
  logic q_empty;
  logic q_pop;

  assign in_valid = push && !full;

  ccrp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .action    (action),
    .char_code (char_code),
    .op_valid  (q_push),
    .op        (q_wdata)
  );

  ccrp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (full),
    .empty (q_empty)
  );

  ccrp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .op_valid      (!q_empty),
    .op            (q_rdata),
    .op_take       (q_pop),
    .pop           (pop),
    .empty         (empty),
    .range_low     (range_low),
    .range_high    (range_high),
    .negated       (negated),
    .is_terminator (is_terminator),
    .last_of_run   (last_of_run)
  );

endmodule
